// ===== rtl/core/unht_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the unique node hash table
package unht_pkg;

    // bucket count must be a power of two: the bucket index is the low bits of the hash sum
    localparam int BUCKETS      = 1024;
    localparam int POOL_ENTRIES = 2048;
    localparam int ID_BITS      = 20;

    localparam int BUCKET_BITS = $clog2(BUCKETS);
    localparam int IDX_BITS    = $clog2(POOL_ENTRIES);
    localparam int COUNT_BITS  = $clog2(POOL_ENTRIES + 1);
    localparam int HASH_BITS   = ID_BITS + 11;

    localparam logic [1:0] KIND_NEG = 2'd3;
    localparam logic       OP_FIND  = 1'b0;
    localparam logic       OP_INS   = 1'b1;

    typedef struct packed {
        logic               op;
        logic [1:0]         kind;
        logic [ID_BITS-1:0] left_id;
        logic [ID_BITS-1:0] right_id;
        logic [ID_BITS-1:0] new_id;
        logic [ID_BITS-1:0] new_var;
    } in_item_t;

    typedef struct packed {
        logic               hit;
        logic               full_res;
        logic [ID_BITS-1:0] node_id;
        logic [ID_BITS-1:0] node_var;
    } out_item_t;

    // classified command handed from front to back
    typedef struct packed {
        logic                   op;
        logic [1:0]             kind;
        logic [ID_BITS-1:0]     left_id;
        logic [ID_BITS-1:0]     right_id;
        logic [ID_BITS-1:0]     new_id;
        logic [ID_BITS-1:0]     new_var;
        logic [BUCKET_BITS-1:0] bucket;
    } cmd_t;

    typedef struct packed {
        logic                valid;
        logic [IDX_BITS-1:0] idx;
    } head_t;

    typedef struct packed {
        logic [1:0]          kind;
        logic [ID_BITS-1:0]  left_id;
        logic [ID_BITS-1:0]  right_id;
        logic [ID_BITS-1:0]  ident;
        logic [ID_BITS-1:0]  nvar;
        logic                next_valid;
        logic [IDX_BITS-1:0] next;
    } entry_t;

endpackage

// ===== rtl/core/unht_front.sv =====
`timescale 1ns / 1ps
// front end: accepts items, folds negation keys, hashes, and queues commands
module unht_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  unht_pkg::in_item_t item,
    output logic              cmd_empty,
    input  logic              cmd_pop,
    output unht_pkg::cmd_t    cmd
);
    import unht_pkg::*;

    // two-entry command queue: one pointer bit per side
    cmd_t                  q_mem [2];
    logic                  wr_ptr_reg, wr_ptr_next;
    logic                  rd_ptr_reg, rd_ptr_next;
    logic [1:0]            cnt_reg, cnt_next;
    logic                  do_push, do_pop;
    logic [ID_BITS-1:0]    right_eff;
    logic [HASH_BITS-1:0]  hash_sum;
    cmd_t                  cmd_in;

    assign full      = (cnt_reg == 2'd2);
    assign cmd_empty = (cnt_reg == 2'd0);
    assign do_push   = push && !full;
    assign do_pop    = cmd_pop && !cmd_empty;
    assign cmd       = q_mem[rd_ptr_reg];

    // negation uses the left operand on both sides of the key
    assign right_eff = (item.kind == KIND_NEG) ? item.left_id : item.right_id;
    assign hash_sum  = HASH_BITS'(item.kind) * HASH_BITS'(2047)
                     + HASH_BITS'(item.left_id) * HASH_BITS'(1023)
                     + HASH_BITS'(right_eff);

    always_comb
    begin
        cmd_in.op       = item.op;
        cmd_in.kind     = item.kind;
        cmd_in.left_id  = item.left_id;
        cmd_in.right_id = right_eff;
        cmd_in.new_id   = item.new_id;
        cmd_in.new_var  = item.new_var;
        cmd_in.bucket   = hash_sum[BUCKET_BITS-1:0];
    end

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_mem[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

// ===== rtl/core/unht_back.sv =====
`timescale 1ns / 1ps
// back end: bucket head memory, entry pool, chain walk and result register
module unht_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_empty,
    output logic                cmd_pop,
    input  unht_pkg::cmd_t      cmd,
    output logic                empty,
    input  logic                pop,
    output unht_pkg::out_item_t result
);
    import unht_pkg::*;

    typedef enum logic [4:0] {
        ST_CLEAR  = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_HEAD   = 5'b00100,
        ST_WALK   = 5'b01000,
        ST_RESULT = 5'b10000
    } state_t;

    head_t  head_mem  [BUCKETS];
    entry_t entry_mem [POOL_ENTRIES];

    state_t                 state_reg, state_next;
    logic [BUCKET_BITS-1:0] clr_reg, clr_next;
    logic [COUNT_BITS-1:0]  count_reg, count_next;
    logic [COUNT_BITS-1:0]  steps_reg, steps_next;
    cmd_t                   cmd_reg, cmd_next;
    out_item_t              res_reg, res_next;
    out_item_t              out_reg, out_next;
    logic                   out_valid_reg, out_valid_next;
    head_t                  head_rd_reg;
    entry_t                 entry_rd_reg;

    logic                   head_we;
    logic [BUCKET_BITS-1:0] head_waddr;
    head_t                  head_wdata;
    logic                   entry_we;
    entry_t                 entry_wdata;
    logic [IDX_BITS-1:0]    entry_raddr;
    logic                   key_match;
    logic                   pool_full;

    assign empty     = !out_valid_reg;
    assign result    = out_reg;
    assign pool_full = (count_reg >= COUNT_BITS'(POOL_ENTRIES));
    assign key_match = (entry_rd_reg.kind == cmd_reg.kind)
                    && (entry_rd_reg.left_id == cmd_reg.left_id)
                    && (entry_rd_reg.right_id == cmd_reg.right_id);
    assign entry_raddr = (state_reg == ST_HEAD) ? head_rd_reg.idx : entry_rd_reg.next;

    always_comb
    begin
        entry_wdata.kind       = cmd_reg.kind;
        entry_wdata.left_id    = cmd_reg.left_id;
        entry_wdata.right_id   = cmd_reg.right_id;
        entry_wdata.ident      = cmd_reg.new_id;
        entry_wdata.nvar       = cmd_reg.new_var;
        entry_wdata.next_valid = head_rd_reg.valid;
        entry_wdata.next       = head_rd_reg.idx;
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        count_next     = count_reg;
        steps_next     = steps_reg;
        cmd_next       = cmd_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        cmd_pop        = 1'b0;
        head_we        = 1'b0;
        head_waddr     = cmd_reg.bucket;
        head_wdata     = '0;
        entry_we       = 1'b0;

        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                head_we    = 1'b1;
                head_waddr = clr_reg;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == BUCKET_BITS'(BUCKETS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop    = 1'b1;
                    cmd_next   = cmd;
                    state_next = ST_HEAD;
                end
            end
            ST_HEAD:
            begin
                res_next   = '0;
                steps_next = '0;
                if (cmd_reg.op == OP_INS)
                begin
                    state_next = ST_RESULT;
                    if (pool_full)
                    begin
                        res_next.full_res = 1'b1;
                    end
                    else
                    begin
                        entry_we         = 1'b1;
                        head_we          = 1'b1;
                        head_wdata.valid = 1'b1;
                        head_wdata.idx   = count_reg[IDX_BITS-1:0];
                        count_next       = count_reg + 1'b1;
                        res_next.hit      = 1'b1;
                        res_next.node_id  = cmd_reg.new_id;
                        res_next.node_var = cmd_reg.new_var;
                    end
                end
                else if (head_rd_reg.valid && (count_reg != '0))
                begin
                    state_next = ST_WALK;
                end
                else
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_WALK:
            begin
                // compare the current entry while the next link is being read
                if (key_match)
                begin
                    res_next.hit      = 1'b1;
                    res_next.node_id  = entry_rd_reg.ident;
                    res_next.node_var = entry_rd_reg.nvar;
                    state_next        = ST_RESULT;
                end
                else if (entry_rd_reg.next_valid && ((steps_reg + 1'b1) < count_reg))
                begin
                    steps_next = steps_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || pop)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        steps_reg <= steps_next;
        cmd_reg   <= cmd_next;
        res_reg   <= res_next;
        out_reg   <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (head_we)
        begin
            head_mem[head_waddr] <= head_wdata;
        end
        head_rd_reg <= head_mem[cmd.bucket];
    end

    // the read address lands on the last written slot only after a full command
    always_ff @(posedge clk)
    begin
        if (entry_we)
        begin
            entry_mem[count_reg[IDX_BITS-1:0]] <= entry_wdata;
        end
        entry_rd_reg <= entry_mem[entry_raddr];
    end

endmodule

// ===== rtl/core/unique_node_hash_table_top.sv =====
`timescale 1ns / 1ps
// top level of the unique node hash table
//
//   channel   handshake            transfer when       payload
//   item      push / full          push && !full       unht_pkg::in_item_t
//   result    empty / pop          pop && !empty       unht_pkg::out_item_t
//
// an insert runs from the back end's idle state through the head read, the write and the result
// a find walks the chain after the head read, comparing one chain entry per entry memory read
// after reset the bucket head memory is cleared before any item runs
// the front end queues two commands, so items are taken while a result waits for pop
module unique_node_hash_table_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  unht_pkg::in_item_t  item,
    output logic                empty,
    input  logic                pop,
    output unht_pkg::out_item_t result
);
    import unht_pkg::*;

    logic cmd_empty;
    logic cmd_pop;
    cmd_t cmd;

    unht_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd)
    );

    unht_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

// ===== verif/unique_node_hash_table_top_test.sv =====
`timescale 1ns / 1ps
// testbench for the unique node hash table: shadow table prediction, random stalls, pool exhaustion
module unique_node_hash_table_top_test;
    import unht_pkg::*;

    localparam logic [1:0] KIND_EQ  = 2'd0;
    localparam logic [1:0] KIND_AND = 2'd1;
    localparam logic [1:0] KIND_OR  = 2'd2;

    localparam longint unsigned HASH_KIND_MUL = 2047;
    localparam longint unsigned HASH_LEFT_MUL = 1023;

    localparam logic [ID_BITS-1:0] ID_ONES = '1;
    localparam logic [ID_BITS-1:0] ID_ALT  = 20'hAAAAA;
    localparam logic [ID_BITS-1:0] ID_ALT2 = 20'h55555;

    localparam int RANDOM_ITEMS   = 1000;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 64;
    localparam int MAX_REPORTS    = 10;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      push = 1'b0;
    logic      pop = 1'b0;
    in_item_t  item = '0;
    logic      full;
    logic      empty;
    out_item_t result;

    // shadow copy of the table
    head_t       heads [BUCKETS];
    entry_t      pool [POOL_ENTRIES];
    int unsigned used_entries;

    out_item_t answers_due [$];
    in_item_t  stored_keys [$];
    int        mismatches = 0;
    int        stall_cycles = 0;
    logic      no_gaps = 1'b0;

    unique_node_hash_table_top DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    always #1 clk = ~clk;

    function automatic int unsigned bucket_index(logic [1:0] k, logic [ID_BITS-1:0] l,
                                                 logic [ID_BITS-1:0] r);
        longint unsigned sum;
        sum = 64'(k) * HASH_KIND_MUL + 64'(l) * HASH_LEFT_MUL + 64'(r);
        return int'(sum % BUCKETS);
    endfunction

    // answers one command and updates the shadow table
    function automatic out_item_t hash_cons_answer(in_item_t it);
        out_item_t           ans;
        entry_t              fresh;
        logic [ID_BITS-1:0]  rkey;
        logic [IDX_BITS-1:0] cur;
        logic                chain_ok;
        int unsigned         b;
        int unsigned         steps;
        ans = '0;
        rkey = (it.kind == KIND_NEG) ? it.left_id : it.right_id;
        b = bucket_index(it.kind, it.left_id, rkey);
        if (it.op == OP_FIND)
        begin
            chain_ok = heads[b].valid;
            cur = heads[b].idx;
            steps = 0;
            while (chain_ok && steps < used_entries)
            begin
                if (pool[cur].kind == it.kind && pool[cur].left_id == it.left_id &&
                    pool[cur].right_id == rkey)
                begin
                    ans.hit = 1'b1;
                    ans.node_id = pool[cur].ident;
                    ans.node_var = pool[cur].nvar;
                    return ans;
                end
                chain_ok = pool[cur].next_valid;
                cur = pool[cur].next;
                steps++;
            end
        end
        else if (used_entries >= POOL_ENTRIES)
        begin
            ans.full_res = 1'b1;
        end
        else
        begin
            fresh.kind = it.kind;
            fresh.left_id = it.left_id;
            fresh.right_id = rkey;
            fresh.ident = it.new_id;
            fresh.nvar = it.new_var;
            fresh.next_valid = heads[b].valid;
            fresh.next = heads[b].idx;
            pool[used_entries] = fresh;
            heads[b].valid = 1'b1;
            heads[b].idx = IDX_BITS'(used_entries);
            used_entries++;
            ans.hit = 1'b1;
            ans.node_id = it.new_id;
            ans.node_var = it.new_var;
        end
        return ans;
    endfunction

    function automatic in_item_t make_item(logic op, logic [1:0] k, logic [ID_BITS-1:0] l,
                                           logic [ID_BITS-1:0] r, logic [ID_BITS-1:0] nid,
                                           logic [ID_BITS-1:0] nvar);
        in_item_t it;
        it.op = op;
        it.kind = k;
        it.left_id = l;
        it.right_id = r;
        it.new_id = nid;
        it.new_var = nvar;
        return it;
    endfunction

    // half of the keys come from a tiny id range so that chains and repeats build up
    function automatic in_item_t random_key(logic op);
        in_item_t it;
        it.op = op;
        it.kind = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 1) == 1)
        begin
            it.left_id = ID_BITS'($urandom);
            it.right_id = ID_BITS'($urandom);
        end
        else
        begin
            it.left_id = ID_BITS'($urandom_range(0, 31));
            it.right_id = ID_BITS'($urandom_range(0, 31));
        end
        it.new_id = ID_BITS'($urandom);
        it.new_var = ID_BITS'($urandom);
        return it;
    endfunction

    // a key already in the table, with fresh payload and a scrambled right id on negations
    function automatic in_item_t stored_key(logic op);
        in_item_t it;
        it = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
        it.op = op;
        it.new_id = ID_BITS'($urandom);
        it.new_var = ID_BITS'($urandom);
        if (it.kind == KIND_NEG)
        begin
            it.right_id = ID_BITS'($urandom);
        end
        return it;
    endfunction

    task automatic send_item(in_item_t it);
        out_item_t ans;
        while (!no_gaps && $urandom_range(0, 99) < 28)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        item <= it;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        ans = hash_cons_answer(it);
        answers_due.push_back(ans);
        if (it.op == OP_INS && ans.hit)
        begin
            stored_keys.push_back(it);
        end
    endtask

    task automatic check_answer(out_item_t got);
        out_item_t want;
        if (answers_due.size() == 0)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
            begin
                $display("unexpected result: hit=%0d full_res=%0d node_id=%h node_var=%h",
                         got.hit, got.full_res, got.node_id, got.node_var);
            end
        end
        else
        begin
            want = answers_due.pop_front();
            if (got.hit !== want.hit || got.full_res !== want.full_res ||
                got.node_id !== want.node_id || got.node_var !== want.node_var)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                begin
                    $display("mismatch: expected hit=%0d full_res=%0d node_id=%h node_var=%h",
                             want.hit, want.full_res, want.node_id, want.node_var);
                    $display("          actual   hit=%0d full_res=%0d node_id=%h node_var=%h",
                             got.hit, got.full_res, got.node_id, got.node_var);
                end
            end
        end
    endtask

    task automatic test_directed();
        // empty table, keys with every field at its top value or at zero
        send_item(make_item(OP_FIND, KIND_NEG, ID_ONES, ID_ONES, ID_ONES, ID_ONES));
        send_item(make_item(OP_INS, KIND_EQ, '0, '0, '0, '0));
        send_item(make_item(OP_INS, KIND_OR, ID_ONES, ID_ONES, ID_ONES, ID_ONES));
        send_item(make_item(OP_FIND, KIND_EQ, '0, '0, ID_ALT, ID_ALT2));
        send_item(make_item(OP_FIND, KIND_OR, ID_ONES, ID_ONES, '0, '0));
        // same operands under each kind
        send_item(make_item(OP_INS, KIND_AND, '0, '0, ID_ALT, ID_ALT2));
        send_item(make_item(OP_INS, KIND_NEG, '0, ID_ONES, ID_ALT2, ID_ALT));
        send_item(make_item(OP_FIND, KIND_AND, '0, '0, '0, '0));
        send_item(make_item(OP_FIND, KIND_OR, '0, '0, '0, '0));
        // negation ignores the right operand
        send_item(make_item(OP_FIND, KIND_NEG, '0, 20'd12345, '0, '0));
        send_item(make_item(OP_FIND, KIND_NEG, '0, '0, '0, '0));
        send_item(make_item(OP_FIND, KIND_EQ, '0, 20'd1, '0, '0));
        // a repeated insert shadows the older entry
        send_item(make_item(OP_INS, KIND_AND, 20'd7, 20'd9, 20'd100, 20'd101));
        send_item(make_item(OP_INS, KIND_AND, 20'd7, 20'd9, 20'd200, 20'd201));
        send_item(make_item(OP_FIND, KIND_AND, 20'd7, 20'd9, '0, '0));
        send_item(make_item(OP_FIND, KIND_AND, 20'd9, 20'd7, '0, '0));
        // equality keys (n, n) all land in bucket zero
        send_item(make_item(OP_INS, KIND_EQ, 20'd1, 20'd1, 20'd11, 20'd12));
        send_item(make_item(OP_INS, KIND_EQ, 20'd2, 20'd2, 20'd21, 20'd22));
        send_item(make_item(OP_FIND, KIND_EQ, '0, '0, '0, '0));
        send_item(make_item(OP_FIND, KIND_EQ, 20'd1, 20'd1, '0, '0));
        send_item(make_item(OP_FIND, KIND_EQ, 20'd3, 20'd3, '0, '0));
    endtask

    task automatic test_random();
        int pick;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            no_gaps = (n >= 300 && n < 500);
            pick = $urandom_range(0, 99);
            if (pick < 8 && stored_keys.size() != 0)
            begin
                send_item(stored_key(OP_INS));
            end
            else if (pick < 35)
            begin
                send_item(random_key(OP_INS));
            end
            else if (pick < 85 && stored_keys.size() != 0)
            begin
                send_item(stored_key(OP_FIND));
            end
            else
            begin
                send_item(random_key(OP_FIND));
            end
        end
        no_gaps = 1'b0;
    endtask

    task automatic test_pool_full();
        while (used_entries < POOL_ENTRIES)
        begin
            send_item(random_key(OP_INS));
        end
        // refused inserts, both new keys and keys already present
        repeat (6)
        begin
            if ($urandom_range(0, 1) == 1)
            begin
                send_item(random_key(OP_INS));
            end
            else
            begin
                send_item(stored_key(OP_INS));
            end
        end
        repeat (40)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                send_item(stored_key(OP_FIND));
            end
            else
            begin
                send_item(random_key(OP_FIND));
            end
        end
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                check_answer(result);
            end
            pop <= no_gaps || ($urandom_range(0, 99) >= 28);
        end
    end

    // counts cycles without any transfer; the bucket clear after reset fits well inside
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        foreach (heads[i])
        begin
            heads[i] = '0;
        end
        used_entries = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random();
        test_pool_full();
        push <= 1'b0;
        while (answers_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && answers_due.size() == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
